// ===== hw/rtl/bracket_aware_list_splitter_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bracket aware list splitter
// Short forms for clocked checks; they expect clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef BRACKET_AWARE_LIST_SPLITTER_MACROS_SVH
`define BRACKET_AWARE_LIST_SPLITTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BALS_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BALS_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bals_pkg.sv =====
// ----------------------------------------------------------------------------
// bals_pkg
// Shared types, widths and character codes of the list splitter.
// ----------------------------------------------------------------------------
package bals_pkg;

  localparam int CHAR_W          = 8;
  localparam int FIELD_START_W   = 12;
  localparam int FIELD_LENGTH_W  = 13;
  localparam int ERROR_POS_W     = 12;

  localparam int DEF_MAX_DEPTH   = 16;
  localparam int DEF_MAX_LEN     = 4096;
  localparam int DEF_RESULT_DEPTH = 4;

  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_EXTRA_CLOSE = 3'd1,
    ERR_MISMATCH    = 3'd2,
    ERR_OPEN_QUOTE  = 3'd3,
    ERR_UNCLOSED    = 3'd4,
    ERR_OVERFLOW    = 3'd5
  } err_code_t;

  typedef struct packed {
    logic                      field_valid;
    logic [FIELD_START_W-1:0]  field_start;
    logic [FIELD_LENGTH_W-1:0] field_length;
    err_code_t                 error_code;
    logic [ERROR_POS_W-1:0]    error_position;
    logic                      is_last;
  } result_t;

  // Up to two results leave the parser for one byte; second implies first.
  typedef struct packed {
    logic    first_valid;
    logic    second_valid;
    result_t first;
    result_t second;
  } push_t;

endpackage

// ===== hw/rtl/bals_parser.sv =====
// ----------------------------------------------------------------------------
// bals_parser
// Per-byte parse state: quotes, bracket stack, field bounds and error latch.
// ----------------------------------------------------------------------------
`include "bracket_aware_list_splitter_macros.svh"

module bals_parser import bals_pkg::*; #(
  parameter int MAX_DEPTH = DEF_MAX_DEPTH,
  parameter int MAX_LEN   = DEF_MAX_LEN
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [CHAR_W-1:0] char_code,
  input  logic              last,
  output push_t             push
);

  localparam int POS_W   = $clog2(MAX_LEN);
  localparam int LEN_W   = POS_W + 1;
  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam int IDX_W   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  logic [MAX_DEPTH-1:0] bracket_stack, bracket_stack_next;
  logic [DEPTH_W-1:0]   nest_depth, nest_depth_next;
  logic                 in_quote, in_quote_next;
  logic                 quote_is_double, quote_is_double_next;
  logic                 escape_pending, escape_pending_next;
  logic [POS_W-1:0]     byte_position, byte_position_next;
  logic [POS_W-1:0]     field_first, field_first_next;
  logic [POS_W-1:0]     field_final, field_final_next;
  logic                 field_has_text, field_has_text_next;
  logic                 string_has_text, string_has_text_next;
  logic                 error_latched, error_latched_next;
  err_code_t            err_code, err_code_next;
  logic [POS_W-1:0]     err_pos, err_pos_next;

  logic                 is_ws, is_open, is_close, text;
  logic                 raise, comma_field;
  err_code_t            raise_code;
  logic [IDX_W-1:0]     top_idx, push_idx;
  logic [CHAR_W-1:0]    quote_char;
  result_t              comma_res, final_res;

  function automatic result_t field_res(input logic has, input logic [POS_W-1:0] first,
                                        input logic [POS_W-1:0] fin, input logic lst);
    result_t r;
    logic [LEN_W-1:0] len;
    len = LEN_W'(fin) - LEN_W'(first) + LEN_W'(1);
    r = '0;
    r.field_valid = 1'b1;
    r.error_code  = ERR_NONE;
    r.is_last     = lst;
    if (has) begin
      r.field_start  = FIELD_START_W'(first);
      r.field_length = FIELD_LENGTH_W'(len);
    end
    return r;
  endfunction

  assign is_ws = (char_code == CH_SPACE) || ((char_code >= CH_TAB) && (char_code <= CH_CR));
  assign is_open = (char_code == CH_LPAREN) || (char_code == CH_LBRACK);
  assign is_close = (char_code == CH_RPAREN) || (char_code == CH_RBRACK);
  assign top_idx = IDX_W'(nest_depth - DEPTH_W'(1));
  assign push_idx = IDX_W'(nest_depth);
  assign quote_char = quote_is_double ? CH_DQUOTE : CH_SQUOTE;

  always_comb begin
    bracket_stack_next   = bracket_stack;
    nest_depth_next      = nest_depth;
    in_quote_next        = in_quote;
    quote_is_double_next = quote_is_double;
    escape_pending_next  = escape_pending;
    field_first_next     = field_first;
    field_final_next     = field_final;
    field_has_text_next  = field_has_text;
    string_has_text_next = string_has_text;
    raise                = 1'b0;
    raise_code           = ERR_NONE;
    comma_field          = 1'b0;
    text                 = !is_ws;

    if (!error_latched) begin
      string_has_text_next = string_has_text | !is_ws;
      if (in_quote) begin
        if (escape_pending) begin
          escape_pending_next = 1'b0;
        end else if (char_code == quote_char) begin
          in_quote_next = 1'b0;
        end else if (char_code == CH_BSLASH) begin
          escape_pending_next = 1'b1;
        end
      end else if (is_open) begin
        if (nest_depth >= DEPTH_W'(MAX_DEPTH)) begin
          raise      = 1'b1;
          raise_code = ERR_OVERFLOW;
        end else begin
          bracket_stack_next[push_idx] = (char_code == CH_LBRACK);
          nest_depth_next = nest_depth + DEPTH_W'(1);
        end
      end else if (is_close) begin
        if (nest_depth == '0) begin
          raise      = 1'b1;
          raise_code = ERR_EXTRA_CLOSE;
        end else if (bracket_stack[top_idx] != (char_code == CH_RBRACK)) begin
          raise      = 1'b1;
          raise_code = ERR_MISMATCH;
        end else begin
          nest_depth_next = nest_depth - DEPTH_W'(1);
        end
      end else if (char_code == CH_COMMA) begin
        if (nest_depth == '0) begin
          comma_field         = 1'b1;
          field_has_text_next = 1'b0;
          field_first_next    = '0;
          field_final_next    = '0;
          text                = 1'b0;
        end
      end else if ((char_code == CH_DQUOTE) || (char_code == CH_SQUOTE)) begin
        in_quote_next        = 1'b1;
        quote_is_double_next = (char_code == CH_DQUOTE);
        escape_pending_next  = 1'b0;
      end

      if (!raise && text) begin
        if (!field_has_text) begin
          field_first_next    = byte_position;
          field_has_text_next = 1'b1;
        end
        field_final_next = byte_position;
      end

      // End-of-string checks; an open quote wins over an open bracket.
      if (!raise && last) begin
        if (in_quote_next) begin
          raise      = 1'b1;
          raise_code = ERR_OPEN_QUOTE;
        end else if (nest_depth_next != '0) begin
          raise      = 1'b1;
          raise_code = ERR_UNCLOSED;
        end
      end
    end

    error_latched_next = error_latched | raise;
    err_code_next      = raise ? raise_code : err_code;
    err_pos_next       = raise ? byte_position : err_pos;
  end

  always_comb begin
    comma_res = field_res(field_has_text, field_first, field_final, 1'b0);
    final_res = '0;
    final_res.error_code = ERR_NONE;
    final_res.is_last    = 1'b1;
    if (error_latched_next) begin
      final_res.error_code     = err_code_next;
      final_res.error_position = ERROR_POS_W'(err_pos_next);
    end else if (string_has_text_next) begin
      final_res = field_res(field_has_text_next, field_first_next, field_final_next, 1'b1);
    end
  end

  assign push.first_valid  = take & (comma_field | last);
  assign push.second_valid = take & comma_field & last;
  assign push.first        = comma_field ? comma_res : final_res;
  assign push.second       = final_res;

  assign byte_position_next = (byte_position < POS_W'(MAX_LEN - 1))
                              ? byte_position + POS_W'(1) : byte_position;

  always_ff @(posedge clk) begin
    if (rst) begin
      bracket_stack   <= '0;
      nest_depth      <= '0;
      in_quote        <= 1'b0;
      quote_is_double <= 1'b0;
      escape_pending  <= 1'b0;
      byte_position   <= '0;
      field_first     <= '0;
      field_final     <= '0;
      field_has_text  <= 1'b0;
      string_has_text <= 1'b0;
      error_latched   <= 1'b0;
      err_code        <= ERR_NONE;
      err_pos         <= '0;
    end else if (take) begin
      if (last) begin
        // The whole parse state returns to its reset value between strings.
        bracket_stack   <= '0;
        nest_depth      <= '0;
        in_quote        <= 1'b0;
        quote_is_double <= 1'b0;
        escape_pending  <= 1'b0;
        byte_position   <= '0;
        field_first     <= '0;
        field_final     <= '0;
        field_has_text  <= 1'b0;
        string_has_text <= 1'b0;
        error_latched   <= 1'b0;
        err_code        <= ERR_NONE;
        err_pos         <= '0;
      end else begin
        bracket_stack   <= bracket_stack_next;
        nest_depth      <= nest_depth_next;
        in_quote        <= in_quote_next;
        quote_is_double <= quote_is_double_next;
        escape_pending  <= escape_pending_next;
        byte_position   <= byte_position_next;
        field_first     <= field_first_next;
        field_final     <= field_final_next;
        field_has_text  <= field_has_text_next;
        string_has_text <= string_has_text_next;
        error_latched   <= error_latched_next;
        err_code        <= err_code_next;
        err_pos         <= err_pos_next;
      end
    end
  end

  `BALS_CHECK(a_depth_bound, 1'b1, nest_depth <= DEPTH_W'(MAX_DEPTH), "bracket depth out of range")
  `BALS_CHECK(a_second_order, push.second_valid, push.first_valid && !push.first.is_last && push.second.is_last, "second result out of order")
  `BALS_CHECK_NEXT(a_string_reset, take && last, byte_position == '0 && !error_latched && nest_depth == '0, "state not cleared after last byte")

endmodule

// ===== hw/rtl/bals_fifo.sv =====
// ----------------------------------------------------------------------------
// bals_fifo
// Small result queue that takes up to two results per cycle and gives one.
// ----------------------------------------------------------------------------
`include "bracket_aware_list_splitter_macros.svh"

module bals_fifo import bals_pkg::*; #(
  parameter int DEPTH = DEF_RESULT_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    room,
  output result_t head,
  output logic    head_valid,
  input  logic    head_ready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  result_t          mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, wr_ptr_next, wr_ptr_plus1, rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0] count, count_next;
  logic             pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign pop          = head_valid & head_ready;
  assign head_valid   = (count != '0);
  assign head         = mem[rd_ptr];
  assign room         = (count <= CNT_W'(DEPTH - 2));
  assign wr_ptr_plus1 = ptr_inc(wr_ptr);

  always_comb begin
    wr_ptr_next = wr_ptr;
    if (push.second_valid) begin
      wr_ptr_next = ptr_inc(wr_ptr_plus1);
    end else if (push.first_valid) begin
      wr_ptr_next = wr_ptr_plus1;
    end
    rd_ptr_next = pop ? ptr_inc(rd_ptr) : rd_ptr;
    count_next  = count + CNT_W'(push.first_valid) + CNT_W'(push.second_valid)
                  - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.first_valid) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.second_valid) begin
      mem[wr_ptr_plus1] <= push.second;
    end
  end

  `BALS_CHECK(a_count_bound, 1'b1, count <= CNT_W'(DEPTH), "result queue count out of range")
  `BALS_CHECK(a_push_room, push.first_valid, count <= CNT_W'(DEPTH - 2), "push without room for two results")
  `BALS_CHECK_NEXT(a_double_push, push.second_valid && !pop, count == $past(count) + CNT_W'(2), "double push miscounted")

endmodule

// ===== hw/rtl/bracket_aware_list_splitter.sv =====
// ----------------------------------------------------------------------------
// bracket_aware_list_splitter
// Splits a byte stream at top-level commas and reports fields and errors.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_ready, char_code, last) carries one byte of
// a parameter string per request; last marks the final byte. The output
// channel (out_valid, out_ready and the result fields) carries one result per
// request. A top-level comma yields a field result; the last byte yields the
// final result, which is a field, a whitespace-only marker, or an error with
// its code and position. A comma on the last byte yields two results.
// Results are registered in the result queue before they are offered.
// Throughput is one byte per cycle while in_ready is high, set by the single
// parse step between the state registers and the result queue.
// The four-entry result queue lets bytes flow while results wait; in_ready
// drops whenever fewer than two entries are free, so a stalled receiver
// holds the input side back once the queue fills.
// Reset (rst, synchronous) clears the parse state and empties the queue.
// ----------------------------------------------------------------------------
module bracket_aware_list_splitter import bals_pkg::*; #(
  parameter int MAX_DEPTH    = DEF_MAX_DEPTH,
  parameter int MAX_LEN      = DEF_MAX_LEN,
  parameter int RESULT_DEPTH = DEF_RESULT_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [CHAR_W-1:0]         char_code,
  input  logic                      last,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      field_valid,
  output logic [FIELD_START_W-1:0]  field_start,
  output logic [FIELD_LENGTH_W-1:0] field_length,
  output logic [2:0]                error_code,
  output logic [ERROR_POS_W-1:0]    error_position,
  output logic                      is_last
);

  // A byte is taken only when the queue can absorb the worst case of two
  // results, so the parser never has to stall in the middle of a byte.
  logic    take;
  push_t   push;
  result_t head;

  assign take = in_valid & in_ready;

  bals_parser #(
    .MAX_DEPTH (MAX_DEPTH),
    .MAX_LEN   (MAX_LEN)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .char_code (char_code),
    .last      (last),
    .push      (push)
  );

  bals_fifo #(
    .DEPTH (RESULT_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (in_ready),
    .head       (head),
    .head_valid (out_valid),
    .head_ready (out_ready)
  );

  // The head of the queue drives the result ports directly.
  assign field_valid    = head.field_valid;
  assign field_start    = head.field_start;
  assign field_length   = head.field_length;
  assign error_code     = head.error_code;
  assign error_position = head.error_position;
  assign is_last        = head.is_last;

endmodule
